// ===== rtl/core/c2s_pkg.sv =====
package c2s_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int DIR_W   = 16;
    localparam int RAD_W   = 31;
    localparam int ANG_W   = 16;
    localparam int ELEV_W  = 15;

    // Square-root chain: 64-bit radicand, 32-bit root, one root bit per cell
    localparam int SQ_IN_W  = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 34;
    localparam int SQ_CELLS = 32;

    // Angle unit: inputs below 2^40 in magnitude, CORDIC datapath with growth margin
    localparam int AT_W  = 41;
    localparam int MAG_W = 40;
    localparam int CX_W  = 43;
    localparam int Z_W   = 33;
    localparam int NORM_STEPS = 6;

    localparam logic [29:0]        QUARTER_PI_Q29 = 30'd421657428;
    localparam logic signed [16:0] PI_Q13         = 17'sd25736;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_ORIGIN_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;

    // One step of the digit-by-digit square root
    typedef struct packed {
        logic [SQ_IN_W-1:0] rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_sqrt_data;

    // One CORDIC vectoring step
    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   nz;
    } t_cordic_data;

    // Per-ray side flags that travel beside the angle datapath
    typedef struct packed {
        logic clamp_hi;
        logic clamp_lo;
        logic zero_dir;
    } t_flags;

    // atan(2^-i) in Q3.29
    function automatic logic [29:0] atan_q29(input int idx);
        logic [29:0] v;
        unique case (idx)
            0:  v = QUARTER_PI_Q29;
            1:  v = 30'd248918915;
            2:  v = 30'd131521918;
            3:  v = 30'd66762579;
            4:  v = 30'd33510843;
            5:  v = 30'd16771758;
            6:  v = 30'd8387925;
            7:  v = 30'd4194219;
            8:  v = 30'd2097141;
            9:  v = 30'd1048575;
            10: v = 30'd524288;
            11: v = 30'd262144;
            12: v = 30'd131072;
            13: v = 30'd65536;
            14: v = 30'd32768;
            15: v = 30'd16384;
            16: v = 30'd8192;
            17: v = 30'd4096;
            18: v = 30'd2048;
            19: v = 30'd1024;
            20: v = 30'd512;
            21: v = 30'd256;
            22: v = 30'd128;
            23: v = 30'd64;
            24: v = 30'd32;
            25: v = 30'd16;
            26: v = 30'd8;
            27: v = 30'd4;
            28: v = 30'd2;
            29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/c2s_sqrt_cell.sv =====
module c2s_sqrt_cell
    import c2s_pkg::*;
(
    input  logic       i_clk,
    input  t_sqrt_data i_d,
    output t_sqrt_data o_d
);

    t_sqrt_data r_d;
    t_sqrt_data n_d;

    // Bring down two radicand bits, try (4*root + 1)
    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {i_d.rem[REM_W-3:0], i_d.rad[SQ_IN_W-1 -: 2]};
        trial  = {i_d.root, 2'b01};
        n_d.rad = {i_d.rad[SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_d.rem  = rem_sh - trial;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_sh;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

// ===== rtl/core/c2s_cordic_cell.sv =====
module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic         i_clk,
    input  t_cordic_data i_d,
    output t_cordic_data o_d
);

    t_cordic_data r_d;
    t_cordic_data n_d;

    // Rotate toward the x axis, direction chosen by the sign of y
    always_comb begin
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [Z_W-1:0]  ang;
        xs  = $signed(i_d.x) >>> IDX;
        ys  = $signed(i_d.y) >>> IDX;
        ang = $signed({3'b000, atan_q29(IDX)});
        n_d.nz = i_d.nz;
        if (!i_d.y[CX_W-1]) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ang;
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

// ===== rtl/core/c2s_atan2.sv =====
module c2s_atan2
    import c2s_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                    i_clk,
    input  logic signed [AT_W-1:0]  i_x,
    input  logic signed [AT_W-1:0]  i_y,
    output logic signed [ANG_W-1:0] o_ang
);

    logic signed [AT_W-1:0]  r_nx [0:NORM_STEPS];
    logic signed [AT_W-1:0]  r_ny [0:NORM_STEPS];
    logic        [MAG_W-1:0] r_nm [0:NORM_STEPS];
    t_cordic_data            r_q;
    t_cordic_data            w_c [0:STAGES];
    logic signed [ANG_W-1:0] r_ang;

    // Entry: larger magnitude of the two inputs, then normalize with a
    // binary shift search that puts the leading one at bit MAG_W-1
    always_ff @(posedge i_clk) begin
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        ax = i_x[AT_W-1] ? MAG_W'(-i_x) : i_x[MAG_W-1:0];
        ay = i_y[AT_W-1] ? MAG_W'(-i_y) : i_y[MAG_W-1:0];
        r_nx[0] <= i_x;
        r_ny[0] <= i_y;
        r_nm[0] <= (ax > ay) ? ax : ay;
        for (int j = 1; j <= NORM_STEPS; j++) begin
            if ((r_nm[j-1] >> (MAG_W - (1 << (NORM_STEPS - j)))) == '0) begin
                r_nx[j] <= r_nx[j-1] <<< (1 << (NORM_STEPS - j));
                r_ny[j] <= r_ny[j-1] <<< (1 << (NORM_STEPS - j));
                r_nm[j] <= r_nm[j-1] << (1 << (NORM_STEPS - j));
            end else begin
                r_nx[j] <= r_nx[j-1];
                r_ny[j] <= r_ny[j-1];
                r_nm[j] <= r_nm[j-1];
            end
        end
    end

    // Quadrant fold: left half-plane turned by a quarter turn
    always_ff @(posedge i_clk) begin
        logic signed [CX_W-1:0] xe;
        logic signed [CX_W-1:0] ye;
        xe = CX_W'(r_nx[NORM_STEPS]);
        ye = CX_W'(r_ny[NORM_STEPS]);
        r_q.nz <= r_nm[NORM_STEPS][MAG_W-1];
        if (xe[CX_W-1] && !ye[CX_W-1]) begin
            r_q.x <= ye;
            r_q.y <= -xe;
            r_q.z <= $signed({2'b00, QUARTER_PI_Q29, 1'b0});
        end else if (xe[CX_W-1]) begin
            r_q.x <= -ye;
            r_q.y <= xe;
            r_q.z <= -$signed({2'b00, QUARTER_PI_Q29, 1'b0});
        end else begin
            r_q.x <= xe;
            r_q.y <= ye;
            r_q.z <= '0;
        end
    end

    assign w_c[0] = r_q;

    for (genvar i = 0; i < STAGES; i++) begin : g_cordic
        c2s_cordic_cell #(.IDX(i)) u_cell (
            .i_clk (i_clk),
            .i_d   (w_c[i]),
            .o_d   (w_c[i+1])
        );
    end

    // Round half up to Q3.13 and limit to +-pi; a zero input gives angle zero
    always_ff @(posedge i_clk) begin
        logic signed [Z_W-1:0] zr;
        logic signed [16:0]    r;
        zr = w_c[STAGES].z + Z_W'(33'sd32768);
        r  = 17'(zr >>> 16);
        if (!w_c[STAGES].nz) begin
            r_ang <= '0;
        end else if (r > PI_Q13) begin
            r_ang <= ANG_W'(PI_Q13);
        end else if (r < -PI_Q13) begin
            r_ang <= ANG_W'(-PI_Q13);
        end else begin
            r_ang <= r[ANG_W-1:0];
        end
    end

    assign o_ang = r_ang;

endmodule

// ===== rtl/core/cartesian_to_spherical_ray.sv =====
// Throughput: one ray per cycle; busy stays low, the pipeline never stalls.
// Latency is set by the 32-cell square-root chain and the CORDIC cell chain.
// Results appear on o_strobe for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the valid pipeline and sets the
// origin to zero and the sphere radius to 1.0.
module cartesian_to_spherical_ray
    import c2s_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Command channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic signed [DIR_W-1:0]   i_dir_x,
    input  logic signed [DIR_W-1:0]   i_dir_y,
    input  logic signed [DIR_W-1:0]   i_dir_z,
    // Result channel
    output logic                     o_strobe,
    output logic [ELEV_W-1:0]        o_pos_elevation,
    output logic signed [ANG_W-1:0]  o_pos_azimuth,
    output logic [ELEV_W-1:0]        o_dir_elevation,
    output logic signed [ANG_W-1:0]  o_dir_azimuth,
    output logic                     o_ratio_clamped,
    output logic                     o_zero_direction,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int LAT  = CORDIC_STAGES + 45;
    localparam int LN_D = 34;
    localparam int FL_D = CORDIC_STAGES + 43;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic signed [DIR_W-1:0]  vx;
        logic signed [DIR_W-1:0]  vy;
        logic signed [DIR_W-1:0]  vz;
    } t_lane;

    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic signed [COORD_W-1:0] r_origin_z;
    logic [RAD_W-1:0]          r_radius;

    logic              w_accept;
    logic [LAT-1:0]    r_vld;
    t_lane             r_s1;
    logic [RAD_W-1:0]  r_rad;
    t_lane             r_ln [0:LN_D-1];
    logic [2*RAD_W-1:0] r_rr;
    logic [2*RAD_W-1:0] r_zz;
    logic [30:0]       r_px2;
    logic [30:0]       r_py2;
    t_flags            n_fl;
    t_flags            r_fl [0:FL_D-1];
    logic [SQ_IN_W-1:0] r_prad;
    logic [SQ_IN_W-1:0] r_drad;
    t_sqrt_data        w_sp [0:SQ_CELLS];
    t_sqrt_data        w_sd [0:SQ_CELLS];
    logic signed [ANG_W-1:0] w_pel;
    logic signed [ANG_W-1:0] w_paz;
    logic signed [ANG_W-1:0] w_del;
    logic signed [ANG_W-1:0] w_daz;
    t_lane             w_lq;
    t_flags            w_fo;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_radius   <= RAD_W'(65536);
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_ORIGIN_Y: r_origin_y <= pwdata;
                REG_ORIGIN_Z: r_origin_z <= pwdata;
                REG_RADIUS:   r_radius   <= pwdata[RAD_W-1:0];
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Y: prdata = r_origin_y;
            REG_ORIGIN_Z: prdata = r_origin_z;
            REG_RADIUS:   prdata = {1'b0, r_radius};
        endcase
    end

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // Stage 1: offset from the origin, zero radius taken as one LSB
    always_ff @(posedge i_clk) begin
        r_s1.dx <= DIFF_W'(i_point_x) - DIFF_W'(r_origin_x);
        r_s1.dy <= DIFF_W'(i_point_y) - DIFF_W'(r_origin_y);
        r_s1.dz <= DIFF_W'(i_point_z) - DIFF_W'(r_origin_z);
        r_s1.vx <= i_dir_x;
        r_s1.vy <= i_dir_y;
        r_s1.vz <= i_dir_z;
        r_rad   <= (r_radius == '0) ? RAD_W'(1) : r_radius;
    end

    // Stage 2: squares and the clamp / zero-direction flags
    always_comb begin
        logic signed [DIFF_W-1:0] srad;
        srad = $signed({2'b00, r_rad});
        n_fl.clamp_hi = r_s1.dz > srad;
        n_fl.clamp_lo = r_s1.dz < -srad;
        n_fl.zero_dir = (r_s1.vx == '0) && (r_s1.vy == '0) && (r_s1.vz == '0);
    end

    always_ff @(posedge i_clk) begin
        logic [DIFF_W-1:0] az;
        logic signed [2*DIR_W-1:0] sx;
        logic signed [2*DIR_W-1:0] sy;
        az = r_s1.dz[DIFF_W-1] ? DIFF_W'(-r_s1.dz) : r_s1.dz;
        sx = r_s1.vx * r_s1.vx;
        sy = r_s1.vy * r_s1.vy;
        r_rr  <= r_rad * r_rad;
        r_zz  <= az[RAD_W-1:0] * az[RAD_W-1:0];
        r_px2 <= sx[30:0];
        r_py2 <= sy[30:0];
    end

    // Stage 3: radicands for both square roots
    always_ff @(posedge i_clk) begin
        logic [31:0] ss;
        ss = {1'b0, r_px2} + {1'b0, r_py2};
        r_prad <= {2'b00, r_rr - r_zz};
        r_drad <= {ss, 32'd0};
    end

    // Operand delay line, stage 2 through stage 35
    always_ff @(posedge i_clk) begin
        r_ln[0] <= r_s1;
        for (int k = 1; k < LN_D; k++) begin
            r_ln[k] <= r_ln[k-1];
        end
    end

    // Flag delay line, stage 2 through the angle outputs
    always_ff @(posedge i_clk) begin
        r_fl[0] <= n_fl;
        for (int k = 1; k < FL_D; k++) begin
            r_fl[k] <= r_fl[k-1];
        end
    end

    // Square-root cell chains
    assign w_sp[0] = '{rad: r_prad, rem: '0, root: '0};
    assign w_sd[0] = '{rad: r_drad, rem: '0, root: '0};

    for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
        c2s_sqrt_cell u_pos (
            .i_clk (i_clk),
            .i_d   (w_sp[i]),
            .o_d   (w_sp[i+1])
        );
        c2s_sqrt_cell u_dir (
            .i_clk (i_clk),
            .i_d   (w_sd[i]),
            .o_d   (w_sd[i+1])
        );
    end

    assign w_lq = r_ln[LN_D-1];

    // Four angle units
    c2s_atan2 #(.STAGES(CORDIC_STAGES)) u_pel (
        .i_clk (i_clk),
        .i_x   (AT_W'(w_lq.dz)),
        .i_y   ($signed({{(AT_W-ROOT_W){1'b0}}, w_sp[SQ_CELLS].root})),
        .o_ang (w_pel)
    );

    c2s_atan2 #(.STAGES(CORDIC_STAGES)) u_paz (
        .i_clk (i_clk),
        .i_x   (AT_W'(w_lq.dx)),
        .i_y   (AT_W'(w_lq.dy)),
        .o_ang (w_paz)
    );

    c2s_atan2 #(.STAGES(CORDIC_STAGES)) u_del (
        .i_clk (i_clk),
        .i_x   (AT_W'($signed({w_lq.vz, 16'd0}))),
        .i_y   ($signed({{(AT_W-ROOT_W){1'b0}}, w_sd[SQ_CELLS].root})),
        .o_ang (w_del)
    );

    c2s_atan2 #(.STAGES(CORDIC_STAGES)) u_daz (
        .i_clk (i_clk),
        .i_x   (AT_W'(w_lq.vx)),
        .i_y   (AT_W'(w_lq.vy)),
        .o_ang (w_daz)
    );

    assign w_fo = r_fl[FL_D-1];

    // Output register: clamp overrides and non-negative elevations
    always_ff @(posedge i_clk) begin
        if (w_fo.clamp_hi) begin
            o_pos_elevation <= '0;
        end else if (w_fo.clamp_lo) begin
            o_pos_elevation <= ELEV_W'(PI_Q13);
        end else if (w_pel[ANG_W-1]) begin
            o_pos_elevation <= '0;
        end else begin
            o_pos_elevation <= w_pel[ELEV_W-1:0];
        end
        o_dir_elevation  <= w_del[ANG_W-1] ? '0 : w_del[ELEV_W-1:0];
        o_pos_azimuth    <= w_paz;
        o_dir_azimuth    <= w_daz;
        o_ratio_clamped  <= w_fo.clamp_hi || w_fo.clamp_lo;
        o_zero_direction <= w_fo.zero_dir;
    end

    assign o_strobe = r_vld[LAT-1];

    // Every accepted ray comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_strobe)
        else $error("ray transfer did not complete after pipeline latency");

    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_zero_direction |-> o_dir_elevation == '0 && o_dir_azimuth == '0)
        else $error("zero direction gave nonzero angles");

    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_pos_elevation <= ELEV_W'(PI_Q13)
                     && o_dir_elevation <= ELEV_W'(PI_Q13))
        else $error("elevation beyond pi");

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_pos_azimuth <= ANG_W'(PI_Q13) && o_pos_azimuth >= -ANG_W'(PI_Q13))
        else $error("position azimuth beyond pi");

endmodule

// ===== verif/cartesian_to_spherical_ray_tb.sv =====
`timescale 1ns / 1ps

module cartesian_to_spherical_ray_tb
    import c2s_pkg::*;
();

    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 45;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1430;

    // Expected angles for one ray
    typedef struct packed {
        logic [ELEV_W-1:0]       pos_el;
        logic signed [ANG_W-1:0] pos_az;
        logic [ELEV_W-1:0]       dir_el;
        logic signed [ANG_W-1:0] dir_az;
        logic                    clamped;
        logic                    zero_dir;
    } t_angles;

    // Holds predicted angles in order and compares each strobed result
    class angle_scoreboard;
        t_angles pending[$];
        int      mismatches;

        function void note_ray(t_angles a);
            pending.insert(pending.size(), a);
        endfunction

        function void check_result(t_angles got);
            t_angles want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp pel=%0d paz=%0d del=%0d daz=%0d c=%b z=%b",
                        want.pos_el, want.pos_az, want.dir_el, want.dir_az,
                        want.clamped, want.zero_dir);
                    $display("          got pel=%0d paz=%0d del=%0d daz=%0d c=%b z=%b",
                        got.pos_el, got.pos_az, got.dir_el, got.dir_az,
                        got.clamped, got.zero_dir);
                end
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] i_point_x, i_point_y, i_point_z;
    logic signed [DIR_W-1:0]   i_dir_x, i_dir_y, i_dir_z;
    logic                      o_strobe;
    logic [ELEV_W-1:0]         o_pos_elevation, o_dir_elevation;
    logic signed [ANG_W-1:0]   o_pos_azimuth, o_dir_azimuth;
    logic                      o_ratio_clamped, o_zero_direction;
    logic                      psel, penable, pwrite;
    logic [3:0]                paddr;
    logic [31:0]               pwdata, prdata;
    logic                      pready;

    cartesian_to_spherical_ray #(.CORDIC_STAGES(STAGES)) uut (.*);

    angle_scoreboard sb;
    logic signed [63:0] org_x, org_y, org_z;
    logic [63:0]        sph_radius;
    logic [63:0]        arctan_tab[30];
    int                 idle_pct;
    int                 quiet_cycles;
    bit                 timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // atan(2^-i) in Q3.29 from the alternating series in Q62
    function automatic void build_arctan();
        logic [63:0] acc, term;
        arctan_tab[0] = 64'(QUARTER_PI_Q29);
        for (int i = 1; i < 30; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
                if (k & 1) acc = acc - term;
                else acc = acc + term;
            end
            arctan_tab[i] = (acc + (64'd1 << 32)) >> 33;
        end
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring rotation: atan2(y, x) rounded to Q3.13 and limited to +-pi
    function automatic logic signed [63:0] vector_angle(logic signed [63:0] x,
                                                        logic signed [63:0] y);
        logic signed [63:0] z, t, r, xs, ys;
        logic [63:0] ax, ay, m;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        m = ax > ay ? ax : ay;
        z = 0;
        if (m == 0) return 0;
        while (m < (64'd1 << 39)) begin
            m = m << 1;
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 2 * 64'(QUARTER_PI_Q29);
            end else begin
                t = x; x = -y; y = t; z = -2 * 64'(QUARTER_PI_Q29);
            end
        end
        for (int i = 0; i < STAGES && i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + $signed(arctan_tab[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - $signed(arctan_tab[i]);
            end
        end
        r = (z + (64'sd1 << 15)) >>> 16;
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic t_angles predict_angles(logic signed [31:0] px, logic signed [31:0] py,
                                               logic signed [31:0] pz, logic signed [15:0] vx,
                                               logic signed [15:0] vy, logic signed [15:0] vz);
        t_angles a;
        logic signed [63:0] dx, dy, dz, rad, pel, del, daz, paz, ex, ey, ez;
        logic [63:0] zz;
        dx = 64'(px) - org_x;
        dy = 64'(py) - org_y;
        dz = 64'(pz) - org_z;
        rad = sph_radius == 0 ? 64'sd1 : $signed(sph_radius);
        a.clamped = 1'b0;
        if (dz > rad) begin
            pel = 0; a.clamped = 1'b1;
        end else if (dz < -rad) begin
            pel = 25736; a.clamped = 1'b1;
        end else begin
            zz = dz < 0 ? -dz : dz;
            pel = vector_angle(dz, $signed(floor_sqrt(rad * rad - zz * zz)));
        end
        ex = 64'(vx); ey = 64'(vy); ez = 64'(vz);
        del = 0; daz = 0;
        a.zero_dir = (vx == 0 && vy == 0 && vz == 0);
        if (!a.zero_dir) begin
            del = vector_angle(ez * 65536, $signed(floor_sqrt((ex * ex + ey * ey) << 32)));
            daz = vector_angle(ex, ey);
        end
        if (pel < 0) pel = 0;
        if (del < 0) del = 0;
        paz = vector_angle(dx, dy);
        a.pos_el = pel[ELEV_W-1:0];
        a.pos_az = paz[ANG_W-1:0];
        a.dir_el = del[ELEV_W-1:0];
        a.dir_az = daz[ANG_W-1:0];
        return a;
    endfunction

    // Register write: setup then access cycle, then psel is dropped before the task returns
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ORIGIN_X: org_x = 64'($signed(val));
            REG_ORIGIN_Y: org_y = 64'($signed(val));
            REG_ORIGIN_Z: org_z = 64'($signed(val));
            REG_RADIUS:   sph_radius = {33'd0, val[30:0]};
        endcase
    endtask

    // One ray transfer, with random idle cycles in front; start stays high
    // for back-to-back transfers and drain lowers it
    task automatic send_ray(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz;
        i_dir_x <= vx; i_dir_y <= vy; i_dir_z <= vz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_ray(predict_angles(px, py, pz, vx, vy, vz));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(3))
            0: return 16'($urandom_range(32768) - 16384);
            1: return 16'($urandom_range(1, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_rays(int n);
        logic [31:0] pz, rad;
        for (int k = 0; k < n; k++) begin
            rad = sph_radius[31:0];
            // mostly points near the sphere so the elevation path is exercised
            if ($urandom_range(3) != 0)
                pz = 32'(org_z) + 32'($signed(64'($urandom) % (64'(rad) * 2 + 3))
                                      - $signed(64'(rad)) - 1);
            else
                pz = $urandom;
            send_ray($urandom, $urandom, pz, rand_dir(), rand_dir(), rand_dir());
        end
    endtask

    // Result sampling and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result({o_pos_elevation, o_pos_azimuth, o_dir_elevation,
                                 o_dir_azimuth, o_ratio_clamped, o_zero_direction});
            if (o_strobe || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        sb = new();
        build_arctan();
        org_x = 0; org_y = 0; org_z = 0; sph_radius = 65536;
        quiet_cycles = 0; timed_out = 1'b0; idle_pct = 38;
        i_rst_n = 1'b0; start = 1'b0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0;
        i_dir_x = 0; i_dir_y = 0; i_dir_z = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 0; pwdata = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rays at reset configuration
        send_ray(0, 0, 0, 0, 0, 0);                       // zero direction, zero offset
        send_ray(0, 0, 32'h0002_0000, 16'h4000, 0, 0);    // ratio above one
        send_ray(0, 0, 32'hFFFE_0000, 0, 16'h4000, 0);    // ratio below minus one
        send_ray(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 16'h4000);  // ratio exactly one
        send_ray(32'hFFFF_0000, 0, 32'hFFFF_0000, 0, 0, 16'hC000);  // ratio exactly minus one
        send_ray(32'hFFFF_0000, 0, 0, 16'hC000, 0, 0);    // negative x axis
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 16'h8000, 16'h8000, 16'h8000);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 16'h8000, 16'h7FFF, 0);
        send_ray(0, 32'hFFFF_0000, 32'h0000_0001, 0, 16'hFFFF, 16'h0001);
        send_ray(32'h0000_0001, 32'hFFFF_FFFF, 0, 16'h0001, 16'hFFFF, 0);
        drain();

        // extreme origin, minimum and zero radius
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Z, 32'h8000_0000);
        write_reg(REG_RADIUS, 32'd1);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h0001);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 16'h1234, 0, 0);
        send_ray(0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        drain();
        write_reg(REG_RADIUS, 32'd0);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 0, 16'h0001, 0);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'h8000);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0002, 16'h0001, 16'h0001, 16'h0001);
        drain();

        // maximum radius, opposite origin extreme
        write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(REG_ORIGIN_Z, 32'h7FFF_FFFF);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 16'h4000, 0);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16'h7FFF);
        send_ray(0, 0, 0, 16'hFFFF, 0, 16'hFFFF);
        random_rays(300);
        drain();

        // sender idles, then idles more often at the reset configuration, then no idling
        write_reg(REG_ORIGIN_X, $urandom);
        write_reg(REG_ORIGIN_Y, $urandom);
        write_reg(REG_ORIGIN_Z, $urandom_range(32'h0010_0000) - 32'h0008_0000);
        write_reg(REG_RADIUS, $urandom_range(32'h0004_0000, 1));
        random_rays(380);
        drain();

        idle_pct = 49;
        write_reg(REG_ORIGIN_X, 0);
        write_reg(REG_ORIGIN_Y, 0);
        write_reg(REG_ORIGIN_Z, 0);
        write_reg(REG_RADIUS, 32'h0001_0000);
        random_rays(380);
        drain();

        idle_pct = 0;
        write_reg(REG_RADIUS, $urandom_range(32'h7FFF_FFFF, 1));
        random_rays(N_RANDOM - 1060);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
